// ===== src/tw7_pkg.sv =====
`default_nettype none

package tw7_pkg;

    localparam logic [7:0]  CMD_DATA_WRITE  = 8'h44;
    localparam logic [7:0]  ADDR_BASE       = 8'hC0;
    localparam logic [7:0]  CMD_DISPLAY_ON  = 8'h8A;
    localparam logic [15:0] PHASE_TICKS_RST = 16'd140;
    localparam logic [2:0]  LAST_TRANSFER   = 3'd5;
    localparam logic [2:0]  LAST_BIT        = 3'd7;
    localparam int          NUM_DIGITS      = 4;

    // One-hot waveform steps: start, eight bits, ack, stop.
    typedef enum logic [14:0] {
        ST_IDLE      = 15'b000000000000001,
        ST_START_HI  = 15'b000000000000010,
        ST_START_DLO = 15'b000000000000100,
        ST_START_CLO = 15'b000000000001000,
        ST_BIT_CLO   = 15'b000000000010000,
        ST_BIT_SET   = 15'b000000000100000,
        ST_BIT_CHI   = 15'b000000001000000,
        ST_ACK_CLO   = 15'b000000010000000,
        ST_ACK_DHI   = 15'b000000100000000,
        ST_ACK_CHI   = 15'b000001000000000,
        ST_ACK       = 15'b000010000000000,
        ST_STOP_CLO  = 15'b000100000000000,
        ST_STOP_DLO  = 15'b001000000000000,
        ST_STOP_CHI  = 15'b010000000000000,
        ST_STOP_DHI  = 15'b100000000000000
    } tw7_step_t;

    typedef struct packed {
        tw7_step_t                      step;
        logic [15:0]                    phase_count;
        logic [2:0]                     transfer_index;
        logic                           byte_index;
        logic [2:0]                     bit_index;
        logic [NUM_DIGITS-1:0][3:0]     digits;
        logic                           clk;
        logic                           dat;
        logic                           drv;
    } tw7_state_t;

    function automatic logic [7:0] seg_byte(input logic [3:0] code);
        logic [7:0] seg;
        case (code)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            4'd10:   seg = 8'h50;  // r
            4'd11:   seg = 8'h79;  // E
            4'd12:   seg = 8'h39;  // C
            4'd13:   seg = 8'h40;  // -
            4'd14:   seg = 8'h38;  // L
            default: seg = 8'h00;  // blank
        endcase
        return seg;
    endfunction

endpackage

`default_nettype wire

// ===== src/tw7_step.sv =====
`default_nettype none

module tw7_step (
    input  var tw7_pkg::tw7_state_t cur,
    input  wire                     kind,
    input  wire [15:0]              digit_codes,
    input  wire                     line_sample,
    input  wire [15:0]              phase_ticks,
    output tw7_pkg::tw7_state_t     nxt,
    output logic                    done
);
    import tw7_pkg::*;

    logic [7:0]  cur_byte;
    logic        cur_bit;
    logic        data_transfer;
    logic [16:0] count_inc;
    logic        phase_end;

    assign data_transfer = (cur.transfer_index >= 3'd1) && (cur.transfer_index <= 3'd4);

    always_comb begin
        if (cur.transfer_index == 3'd0) begin
            cur_byte = CMD_DATA_WRITE;
        end else if (data_transfer) begin
            if (cur.byte_index) begin
                cur_byte = seg_byte(cur.digits[cur.transfer_index[1:0] - 2'd1]);
            end else begin
                cur_byte = ADDR_BASE + {6'd0, cur.transfer_index[1:0] - 2'd1};
            end
        end else begin
            cur_byte = CMD_DISPLAY_ON;
        end
    end

    // LSB first
    assign cur_bit   = cur_byte[cur.bit_index];
    assign count_inc = {1'b0, cur.phase_count} + 17'd1;
    assign phase_end = count_inc >= {1'b0, phase_ticks};

    always_comb begin
        nxt  = cur;
        done = 1'b0;
        if (kind) begin
            if (cur.step == ST_IDLE) begin
                nxt.digits         = digit_codes;
                nxt.phase_count    = '0;
                nxt.transfer_index = '0;
                nxt.byte_index     = 1'b0;
                nxt.bit_index      = '0;
                nxt.step           = ST_START_HI;
                nxt.clk            = 1'b1;
                nxt.dat            = 1'b1;
                nxt.drv            = 1'b1;
            end
        end else if (cur.step != ST_IDLE) begin
            if (cur.step == ST_ACK) begin
                if (!line_sample) begin
                    nxt.drv         = 1'b1;
                    nxt.phase_count = '0;
                    nxt.clk         = 1'b0;
                    if (data_transfer && !cur.byte_index) begin
                        nxt.byte_index = 1'b1;
                        nxt.bit_index  = '0;
                        nxt.step       = ST_BIT_CLO;
                    end else begin
                        nxt.step = ST_STOP_CLO;
                    end
                end
            end else if (phase_end) begin
                nxt.phase_count = '0;
                case (cur.step)
                    ST_START_HI: begin
                        nxt.step = ST_START_DLO;
                        nxt.dat  = 1'b0;
                    end
                    ST_START_DLO: begin
                        nxt.step = ST_START_CLO;
                        nxt.clk  = 1'b0;
                    end
                    ST_START_CLO: begin
                        nxt.step = ST_BIT_CLO;
                        nxt.clk  = 1'b0;
                    end
                    ST_BIT_CLO: begin
                        nxt.step = ST_BIT_SET;
                        nxt.dat  = cur_bit;
                    end
                    ST_BIT_SET: begin
                        nxt.step = ST_BIT_CHI;
                        nxt.clk  = 1'b1;
                    end
                    ST_BIT_CHI: begin
                        nxt.clk = 1'b0;
                        if (cur.bit_index == LAST_BIT) begin
                            nxt.bit_index = '0;
                            nxt.step      = ST_ACK_CLO;
                        end else begin
                            nxt.bit_index = cur.bit_index + 3'd1;
                            nxt.step      = ST_BIT_CLO;
                        end
                    end
                    ST_ACK_CLO: begin
                        nxt.step = ST_ACK_DHI;
                        nxt.dat  = 1'b1;
                    end
                    ST_ACK_DHI: begin
                        nxt.step = ST_ACK_CHI;
                        nxt.clk  = 1'b1;
                    end
                    ST_ACK_CHI: begin
                        nxt.step = ST_ACK;
                        nxt.drv  = 1'b0;
                    end
                    ST_STOP_CLO: begin
                        nxt.step = ST_STOP_DLO;
                        nxt.dat  = 1'b0;
                    end
                    ST_STOP_DLO: begin
                        nxt.step = ST_STOP_CHI;
                        nxt.clk  = 1'b1;
                    end
                    ST_STOP_CHI: begin
                        nxt.step = ST_STOP_DHI;
                        nxt.dat  = 1'b1;
                    end
                    ST_STOP_DHI: begin
                        if (cur.transfer_index >= LAST_TRANSFER) begin
                            nxt.step           = ST_IDLE;
                            nxt.transfer_index = '0;
                            nxt.byte_index     = 1'b0;
                            nxt.bit_index      = '0;
                            done               = 1'b1;
                        end else begin
                            nxt.transfer_index = cur.transfer_index + 3'd1;
                            nxt.byte_index     = 1'b0;
                            nxt.bit_index      = '0;
                            nxt.step           = ST_START_HI;
                            nxt.clk            = 1'b1;
                            nxt.dat            = 1'b1;
                            nxt.drv            = 1'b1;
                        end
                    end
                    default: begin
                        nxt.step           = ST_IDLE;
                        nxt.transfer_index = '0;
                        nxt.byte_index     = 1'b0;
                        nxt.bit_index      = '0;
                    end
                endcase
            end else begin
                nxt.phase_count = count_inc[15:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/two_wire_seven_segment_driver_top.sv =====
`default_nettype none

// Channel   Dir  Beat fields (low bit up)
// s_*       in   tuser: kind | tdata: digit_first..digit_fourth, line_sample
// m_*       out  tdata: clock_level, data_level, data_drive, busy_res, finished
// cfg_*     in   phase_ticks write, no read-back
//
// One beat per cycle while s_tready is high: the pin state machine steps once per
// input beat and the result is registered in a single output register.
// s_tready drops only while the output register is full and m_tready is low.
// aresetn (sync, active low) puts the pins at clock high, data high, driving,
// idle, and phase_ticks at 140.

module two_wire_seven_segment_driver_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,   // digit_first, digit_second, digit_third,
                                   // digit_fourth, line_sample, 7'b0
    input  wire  [0:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,   // clock_level, data_level, data_drive,
                                   // busy_res, finished, 3'b0
    input  wire         cfg_we,
    input  wire  [15:0] cfg_wdata
);
    import tw7_pkg::*;

    tw7_state_t  state_reg;
    tw7_state_t  state_next;
    logic        done;
    logic [15:0] phase_ticks_reg;
    logic        m_valid_reg;
    logic [7:0]  m_data_reg;
    logic        accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    tw7_step u_step (
        .cur         (state_reg),
        .kind        (s_tuser[0]),
        .digit_codes (s_tdata[15:0]),
        .line_sample (s_tdata[16]),
        .phase_ticks (phase_ticks_reg),
        .nxt         (state_next),
        .done        (done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_RST;
        end else if (cfg_we) begin
            phase_ticks_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.step           <= ST_IDLE;
            state_reg.phase_count    <= '0;
            state_reg.transfer_index <= '0;
            state_reg.byte_index     <= 1'b0;
            state_reg.bit_index      <= '0;
            state_reg.digits         <= '0;
            state_reg.clk            <= 1'b1;
            state_reg.dat            <= 1'b1;
            state_reg.drv            <= 1'b1;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {3'b000, done, (state_next.step != ST_IDLE),
                           state_next.drv, state_next.dat, state_next.clk};
        end
    end

`ifndef SYNTH
    a_step_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg.step))
        else $error("step register not one-hot");

    a_release_only_in_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.drv |-> state_reg.step == ST_ACK)
        else $error("data line released outside ack wait");

    a_bit_index_in_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.bit_index != 3'd0 |->
            state_reg.step == ST_BIT_CLO || state_reg.step == ST_BIT_SET ||
            state_reg.step == ST_BIT_CHI)
        else $error("bit index live outside a byte");

    a_finish_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[4] |-> !m_data_reg[3])
        else $error("finished beat still flagged busy");
`endif

endmodule

`default_nettype wire
